### hw/rtl/sfd_pkg.sv
// sfd_pkg: shared types and constants of the sensor frame deframer
// used by sfd_parser, sfd_emitter and sensor_frame_deframer; no dependencies
package sfd_pkg;

  localparam int unsigned ChannelsDef = 6;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned WordW       = 32;
  localparam int unsigned IndexW      = 3;
  localparam int unsigned LenW        = 16;

  localparam logic [ByteW-1:0] HdrFirst  = 8'hAA;
  localparam logic [ByteW-1:0] HdrSecond = 8'h55;

  localparam logic [LenW-1:0] MinEmitLen  = 16'd27;
  localparam logic [LenW-1:0] WordsOffset = 16'd6;
  localparam logic [LenW-1:0] LengthEnd   = 16'd4;
  localparam logic [LenW-1:0] LenLowPos   = 16'd2;
  localparam logic [LenW-1:0] LenHighPos  = 16'd3;

  typedef enum logic [1:0] {
    PhHunt   = 2'd0,
    PhSawAa  = 2'd1,
    PhLength = 2'd2,
    PhBody   = 2'd3
  } phase_e;

endpackage

### hw/rtl/sfd_parser.sv
// sfd_parser: header hunt, length capture, byte counting and channel word store
// depends on sfd_pkg
module sfd_parser import sfd_pkg::*; #(
  parameter int unsigned Channels = ChannelsDef,
  parameter int unsigned CountW   = $clog2(Channels + 1),
  parameter int unsigned SlotW    = (Channels > 1) ? $clog2(Channels) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [ByteW-1:0]               rx_byte_i,
  output logic                           last_emit_o,
  output logic                           emit_o,
  output logic [CountW-1:0]              count_o,
  output logic [Channels-1:0][WordW-1:0] words_o
);

  phase_e                          phase_q, phase_d;
  logic [LenW-1:0]                 len_q, len_d;
  logic [LenW-1:0]                 pos_q, pos_d;
  logic [Channels-1:0][WordW-1:0]  store_q, store_d;

  logic [LenW-1:0]   rel;
  logic [LenW-3:0]   slot;
  logic              in_range;
  logic              at_end;
  logic              long_frame;
  logic [LenW:0]     pos_inc;
  logic [LenW-1:0]   len_full;
  logic [LenW-1:0]   len_rel;

  assign rel        = pos_q - WordsOffset;
  assign slot       = rel[LenW-1:2];
  assign in_range   = (pos_q >= WordsOffset) && (slot < (LenW-2)'(Channels));
  assign pos_inc    = {1'b0, pos_q} + {{LenW{1'b0}}, 1'b1};
  assign at_end     = pos_inc >= {1'b0, len_q};
  assign long_frame = len_q >= MinEmitLen;
  assign len_full   = {rx_byte_i, len_q[ByteW-1:0]};

  assign last_emit_o = (phase_q == PhBody) && at_end && long_frame;

  // word count: (len - 6) / 4 capped at the channel count
  logic [LenW-3:0] quot;
  assign len_rel = len_q - WordsOffset;
  assign quot    = len_rel[LenW-1:2];

  always_comb begin
    if (quot > (LenW-2)'(Channels)) begin
      count_o = CountW'(Channels);
    end else begin
      count_o = quot[CountW-1:0];
    end
  end

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    pos_d   = pos_q;
    store_d = store_q;
    emit_o  = 1'b0;
    if (accept_i) begin
      case (phase_q)
        PhHunt: begin
          if (rx_byte_i == HdrFirst) begin
            phase_d = PhSawAa;
          end
        end
        PhSawAa: begin
          if (rx_byte_i == HdrSecond) begin
            phase_d = PhLength;
            pos_d   = LenLowPos;
            len_d   = '0;
          end else if (rx_byte_i != HdrFirst) begin
            phase_d = PhHunt;
          end
        end
        PhLength: begin
          if (pos_q == LenLowPos) begin
            len_d = {{(LenW-ByteW){1'b0}}, rx_byte_i};
            pos_d = LenHighPos;
          end else begin
            len_d = len_full;
            if (len_full <= LengthEnd) begin
              phase_d = PhHunt;
              pos_d   = '0;
            end else begin
              phase_d = PhBody;
              pos_d   = LengthEnd;
            end
          end
        end
        PhBody: begin
          if (in_range) begin
            store_d[slot[SlotW-1:0]][{rel[1:0], 3'b000} +: ByteW] = rx_byte_i;
          end
          if (at_end) begin
            emit_o  = long_frame;
            phase_d = PhHunt;
            pos_d   = '0;
          end else begin
            pos_d = pos_inc[LenW-1:0];
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  assign words_o = store_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

endmodule

### hw/rtl/sfd_emitter.sv
// sfd_emitter: holds a snapshot of one frame's channel words and drains them in order
// depends on sfd_pkg
module sfd_emitter import sfd_pkg::*; #(
  parameter int unsigned Channels = ChannelsDef,
  parameter int unsigned CountW   = $clog2(Channels + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [CountW-1:0]              count_i,
  input  logic [Channels-1:0][WordW-1:0] words_i,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [IndexW-1:0]              channel_index_o,
  output logic [WordW-1:0]               channel_word_o,
  output logic                           frame_last_o
);

  logic                           busy_q, busy_d;
  logic [CountW-1:0]              count_q, count_d;
  logic [CountW-1:0]              idx_q, idx_d;
  logic [Channels-1:0][WordW-1:0] words_q;
  logic                           pop;
  logic [CountW-1:0]              idx_inc;

  assign pop     = busy_q && out_ready_i;
  assign idx_inc = idx_q + CountW'(1);

  assign busy_o          = busy_q;
  assign out_valid_o     = busy_q;
  assign channel_index_o = IndexW'(idx_q);
  assign channel_word_o  = words_q[0];
  assign frame_last_o    = (idx_inc == count_q);

  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (load_i) begin
      busy_d  = 1'b1;
      count_d = count_i;
      idx_d   = '0;
    end else if (pop) begin
      idx_d = idx_inc;
      if (idx_inc == count_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // shift line: the head word is always the next transaction
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= words_i;
    end else if (pop) begin
      for (int i = 0; i < Channels - 1; i++) begin
        words_q[i] <= words_q[i+1];
      end
    end
  end

endmodule

### hw/rtl/sensor_frame_deframer.sv
// sensor_frame_deframer: top level of the length-prefixed sensor frame deframer
// depends on sfd_pkg, sfd_parser and sfd_emitter
//
// usage: bytes enter on rx_byte_i with in_valid_i/in_ready_o, one per cycle.
// the parser hunts for 0xAA 0x55, reads a little-endian 16-bit length that
// counts the whole frame and stores channel words from offset 6 on.
// on the last byte of a frame of length 27 or more, the stored words are
// copied into the output shift line and leave on out_valid_o/out_ready_i,
// one transaction per word, channel_index_o counting up, frame_last_o on the
// final word. shorter frames produce nothing.
// latency: the first word is valid the cycle after the last frame byte is
// accepted; the burst advances word by word while out_ready_i is high.
// throughput: one byte per cycle; the only stall is the last byte of an
// emitting frame while the previous burst is still draining.
// reset: parser returns to header hunt, the output side goes empty.
// receiver stall: words hold in place and parsing of the next frame
// continues until its own last byte.
module sensor_frame_deframer import sfd_pkg::*; #(
  parameter int unsigned Channels = ChannelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IndexW-1:0] channel_index_o,
  output logic [WordW-1:0]  channel_word_o,
  output logic              frame_last_o
);

  localparam int unsigned CountW = $clog2(Channels + 1);

  logic                           accept;
  logic                           last_emit;
  logic                           emit;
  logic                           busy;
  logic [CountW-1:0]              count;
  logic [Channels-1:0][WordW-1:0] words;

  assign in_ready_o = !busy || !last_emit;
  assign accept     = in_valid_i && in_ready_o;

  sfd_parser #(
    .Channels (Channels),
    .CountW   (CountW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .last_emit_o (last_emit),
    .emit_o      (emit),
    .count_o     (count),
    .words_o     (words)
  );

  sfd_emitter #(
    .Channels (Channels),
    .CountW   (CountW)
  ) u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (emit),
    .count_i         (count),
    .words_i         (words),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_index_o (channel_index_o),
    .channel_word_o  (channel_word_o),
    .frame_last_o    (frame_last_o)
  );

endmodule
